@@ hw/rtl/selu_pkg.sv @@
// Shared constants, types and table functions for the SELU activation unit.
`default_nettype none

package selu_pkg;

  localparam int unsigned ExpSegments = 64;
  localparam int unsigned InRange     = 32768;
  localparam int unsigned XW          = 16;
  localparam int unsigned GW          = 16;
  localparam int unsigned RW          = 18;
  localparam int unsigned UW          = 17;
  localparam int unsigned RomW        = 31;
  localparam int unsigned CoefW       = 17;
  localparam int unsigned SumW        = 20;

  localparam logic [CoefW-1:0]     ScaleQ16  = 17'd68858;
  localparam logic [CoefW-1:0]     AScaleQ16 = 17'd115221;
  localparam logic [RomW-1:0]      OneQ30    = 31'h4000_0000;
  localparam logic signed [RW-1:0] OutMax    = 18'sh1FFFF;
  localparam logic signed [RW-1:0] OutMin    = 18'sh20000;

  typedef enum logic {
    OpForward  = 1'b0,
    OpBackward = 1'b1
  } op_e;

  typedef struct packed {
    op_e                   op;
    logic                  pos;
    logic signed [XW-1:0]  x;
    logic signed [GW-1:0]  grad;
  } side_t;

  // exp(-step/4096) in Q30 from a truncated Taylor series
  function automatic logic [63:0] exp_decay(int unsigned step);
    logic [63:0] t;
    logic [63:0] term;
    longint      sum;
    logic [63:0] d;
    t    = 64'(step) << 18;
    term = 64'(OneQ30);
    sum  = longint'(64'(OneQ30));
    for (int unsigned n = 1; n <= 24; n++) begin
      term = ((term * t) >> 30) / 64'(n);
      if (n[0]) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    d = (sum > 0) ? 64'(sum) : 64'd0;
    if (d > 64'(OneQ30)) begin
      d = 64'(OneQ30);
    end
    return d;
  endfunction

  // k-th knot of the exp table in Q30
  function automatic logic [63:0] exp_entry(int unsigned k, logic [63:0] d);
    logic [63:0] e;
    e = 64'(OneQ30);
    for (int unsigned j = 0; j < k; j++) begin
      e = (e * d + (64'd1 << 29)) >> 30;
    end
    return e;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/selu_if.sv @@
// Valid/ready channel interfaces for SELU input and result transfers.
`default_nettype none

interface selu_in_if;
  logic                               valid;
  logic                               ready;
  logic                               op;
  logic signed [selu_pkg::XW-1:0]     x_value;
  logic signed [selu_pkg::GW-1:0]     grad_in;

  modport source (output valid, op, x_value, grad_in, input ready);
  modport sink   (input valid, op, x_value, grad_in, output ready);
endinterface

interface selu_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [selu_pkg::RW-1:0]     result_value;
  logic                               saturated;

  modport source (output valid, result_value, saturated, input ready);
  modport sink   (input valid, result_value, saturated, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/selu_cdiv.sv @@
// Two-stage divide by a constant: reciprocal multiply, then one correction step.
`default_nettype none

module selu_cdiv #(
  parameter int unsigned Divisor = 512,
  parameter int unsigned NumW    = 17,
  parameter int unsigned SideW   = 1,
  localparam int unsigned RemW   = $clog2(Divisor)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [NumW-1:0]  num_i,
  input  logic [SideW-1:0] side_i,
  output logic             valid_o,
  output logic [NumW-1:0]  quot_o,
  output logic [RemW-1:0]  rem_o,
  output logic [SideW-1:0] side_o
);

  localparam int unsigned     ProdW = NumW + 32;
  localparam logic [31:0]     Recip = 32'((64'd1 << 32) / Divisor);
  localparam logic [NumW-1:0] DivN  = NumW'(Divisor);

  logic [ProdW-1:0] prod_d, prod_q;
  logic [NumW-1:0]  num_q;
  logic [SideW-1:0] side1_q;
  logic             valid1_q;
  logic [NumW-1:0]  q0, r0;
  logic             fix;
  logic [NumW-1:0]  quot_d, quot_q;
  logic [RemW-1:0]  rem_d, rem_q;
  logic [SideW-1:0] side2_q;
  logic             valid2_q;

  assign prod_d = ProdW'(num_i) * ProdW'(Recip);

  always_comb begin
    q0     = prod_q[ProdW-1:32];
    r0     = num_q - NumW'(q0 * DivN);
    fix    = (r0 >= DivN);
    quot_d = fix ? q0 + NumW'(1) : q0;
    rem_d  = fix ? RemW'(r0 - DivN) : RemW'(r0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid1_q <= 1'b0;
      valid2_q <= 1'b0;
    end else if (en_i) begin
      valid1_q <= valid_i;
      valid2_q <= valid1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q  <= prod_d;
      num_q   <= num_i;
      side1_q <= side_i;
      quot_q  <= quot_d;
      rem_q   <= rem_d;
      side2_q <= side1_q;
    end
  end

  assign valid_o = valid2_q;
  assign quot_o  = quot_q;
  assign rem_o   = rem_q;
  assign side_o  = side2_q;

endmodule

`default_nettype wire

@@ hw/rtl/selu_exp_interp.sv @@
// Piecewise-linear exp over the negative range: table lookup and rounded interpolation.
`default_nettype none

module selu_exp_interp #(
  parameter int unsigned ExpSegments = selu_pkg::ExpSegments,
  localparam int unsigned Step  = selu_pkg::InRange / ExpSegments,
  localparam int unsigned Segs  = selu_pkg::InRange / Step + 1,
  localparam int unsigned IdxW  = $clog2(Segs),
  localparam int unsigned FracW = $clog2(Step)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic [IdxW-1:0]             idx_i,
  input  logic [FracW-1:0]            frac_i,
  input  selu_pkg::side_t             side_i,
  output logic                        valid_o,
  output logic [selu_pkg::RomW-1:0]   exp_o,
  output selu_pkg::side_t             side_o
);

  localparam int unsigned RomW  = selu_pkg::RomW;
  localparam int unsigned N2W   = $clog2(Step * Step);
  localparam int unsigned Half  = Step / 2;
  localparam int unsigned SideW = $bits(selu_pkg::side_t) + 2 * RomW;
  localparam logic [63:0] Decay = selu_pkg::exp_decay(Step);

  logic [RomW-1:0]  rom_a  [Segs];
  logic [RomW-1:0]  rom_dq [Segs];
  logic [FracW-1:0] rom_dr [Segs];

  for (genvar k = 0; k < Segs; k++) begin : g_rom
    localparam logic [63:0] EHi   = selu_pkg::exp_entry(k, Decay);
    localparam logic [63:0] ELo   = selu_pkg::exp_entry(k + 1, Decay);
    localparam logic [63:0] Diff  = EHi - ELo;
    localparam logic [63:0] DiffQ = Diff / Step;
    localparam logic [63:0] DiffR = Diff % Step;
    assign rom_a[k]  = RomW'(EHi);
    assign rom_dq[k] = RomW'(DiffQ);
    assign rom_dr[k] = FracW'(DiffR);
  end

  // split the slope term: dq*f exactly, dr*f through the constant divider
  logic [RomW-1:0]         lin_d, lin_q;
  logic [RomW-1:0]         base_q;
  logic [N2W-1:0]          num_d, num_q;
  selu_pkg::side_t         side_q;
  logic                    valid_q;

  assign lin_d = RomW'((RomW + FracW)'(rom_dq[idx_i]) * (RomW + FracW)'(frac_i));
  assign num_d = N2W'(N2W'(rom_dr[idx_i]) * N2W'(frac_i)) + N2W'(Half);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      base_q <= rom_a[idx_i];
      lin_q  <= lin_d;
      num_q  <= num_d;
      side_q <= side_i;
    end
  end

  logic                    dv_valid;
  logic [N2W-1:0]          dv_quot;
  logic [FracW-1:0]        dv_rem;
  logic [SideW-1:0]        dv_side;
  selu_pkg::side_t         dv_item;
  logic [RomW-1:0]         dv_base, dv_lin;

  selu_cdiv #(
    .Divisor (Step),
    .NumW    (N2W),
    .SideW   (SideW)
  ) u_round_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en_i),
    .valid_i (valid_q),
    .num_i   (num_q),
    .side_i  ({side_q, base_q, lin_q}),
    .valid_o (dv_valid),
    .quot_o  (dv_quot),
    .rem_o   (dv_rem),
    .side_o  (dv_side)
  );

  assign {dv_item, dv_base, dv_lin} = dv_side;

  logic [RomW-1:0] exp_d, exp_q;
  selu_pkg::side_t side_out_q;
  logic            valid_out_q;
  logic            unused_rem;

  assign unused_rem = ^dv_rem;
  assign exp_d      = dv_base - dv_lin - RomW'(dv_quot);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_out_q <= 1'b0;
    end else if (en_i) begin
      valid_out_q <= dv_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      exp_q      <= unused_rem ? exp_d : exp_d;
      side_out_q <= dv_item;
    end
  end

  assign valid_o = valid_out_q;
  assign exp_o   = exp_q;
  assign side_o  = side_out_q;

endmodule

`default_nettype wire

@@ hw/rtl/selu_scale.sv @@
// SELU scaling, gradient product, rounding and saturation, ending in the result register.
`default_nettype none

module selu_scale (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            en_i,
  input  logic                            valid_i,
  input  logic [selu_pkg::RomW-1:0]       exp_i,
  input  selu_pkg::side_t                 side_i,
  output logic                            valid_o,
  output logic signed [selu_pkg::RW-1:0]  result_o,
  output logic                            sat_o
);

  localparam int unsigned RomW  = selu_pkg::RomW;
  localparam int unsigned CoefW = selu_pkg::CoefW;
  localparam int unsigned GW    = selu_pkg::GW;
  localparam int unsigned RW    = selu_pkg::RW;
  localparam int unsigned SumW  = selu_pkg::SumW;
  localparam int unsigned PW    = RomW + CoefW;
  localparam int unsigned P2W   = CoefW + GW;

  // stage: one multiply by the selected coefficient
  logic [RomW-1:0]  opa;
  logic [CoefW-1:0] coef;
  logic [PW-1:0]    prod_d, prod_q;
  selu_pkg::side_t  side1_q;
  logic             valid1_q;

  always_comb begin
    if (side_i.pos) begin
      opa  = RomW'($unsigned(side_i.x));
      coef = selu_pkg::ScaleQ16;
    end else if (side_i.op == selu_pkg::OpForward) begin
      opa  = selu_pkg::OneQ30 - exp_i;
      coef = selu_pkg::AScaleQ16;
    end else begin
      opa  = exp_i;
      coef = selu_pkg::AScaleQ16;
    end
    prod_d = PW'(opa) * PW'(coef);
  end

  // stage: round forward result and derivative, take gradient magnitude
  logic [PW-1:0]          rnd16, rnd30, rnd34;
  logic signed [SumW-1:0] fwd_d, fwd_q;
  logic [CoefW-1:0]       deriv_d, deriv_q;
  logic [GW-1:0]          gmag_d, gmag_q;
  logic                   gneg_q;
  selu_pkg::op_e          op2_q;
  logic                   valid2_q;

  always_comb begin
    rnd16   = (prod_q + (PW'(1) << 15)) >> 16;
    rnd30   = (prod_q + (PW'(1) << 29)) >> 30;
    rnd34   = (prod_q + (PW'(1) << 33)) >> 34;
    fwd_d   = side1_q.pos ? SumW'(rnd16) : -SumW'(rnd34);
    deriv_d = side1_q.pos ? selu_pkg::ScaleQ16 : CoefW'(rnd30);
    gmag_d  = side1_q.grad[GW-1] ? GW'(-side1_q.grad) : GW'(side1_q.grad);
  end

  // stage: derivative times gradient magnitude
  logic [P2W-1:0]         p2_d, p2_q;
  logic signed [SumW-1:0] fwd3_q;
  logic                   gneg3_q;
  selu_pkg::op_e          op3_q;
  logic                   valid3_q;

  assign p2_d = P2W'(deriv_q) * P2W'(gmag_q);

  // output stage: sign, select, clip
  logic [P2W-1:0]         mag;
  logic signed [SumW-1:0] bwd, r;
  logic signed [RW-1:0]   result_d, result_q;
  logic                   sat_d, sat_q;
  logic                   valid4_q;

  always_comb begin
    mag = (p2_q + (P2W'(1) << 15)) >> 16;
    bwd = gneg3_q ? -SumW'(mag) : SumW'(mag);
    r   = (op3_q == selu_pkg::OpBackward) ? bwd : fwd3_q;
    if (r > SumW'(selu_pkg::OutMax)) begin
      result_d = selu_pkg::OutMax;
      sat_d    = 1'b1;
    end else if (r < SumW'(selu_pkg::OutMin)) begin
      result_d = selu_pkg::OutMin;
      sat_d    = 1'b1;
    end else begin
      result_d = RW'(r);
      sat_d    = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid1_q <= 1'b0;
      valid2_q <= 1'b0;
      valid3_q <= 1'b0;
      valid4_q <= 1'b0;
    end else if (en_i) begin
      valid1_q <= valid_i;
      valid2_q <= valid1_q;
      valid3_q <= valid2_q;
      valid4_q <= valid3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q   <= prod_d;
      side1_q  <= side_i;
      fwd_q    <= fwd_d;
      deriv_q  <= deriv_d;
      gmag_q   <= gmag_d;
      gneg_q   <= side1_q.grad[GW-1];
      op2_q    <= side1_q.op;
      p2_q     <= p2_d;
      fwd3_q   <= fwd_q;
      gneg3_q  <= gneg_q;
      op3_q    <= op2_q;
      result_q <= result_d;
      sat_q    <= sat_d;
    end
  end

  assign valid_o  = valid4_q;
  assign result_o = result_q;
  assign sat_o    = sat_q;

endmodule

`default_nettype wire

@@ hw/rtl/selu_activation_unit.sv @@
// Top level of the SELU activation unit: segment split, exp interpolation and scaling.
// Throughput one item per cycle; the pipeline advances as a whole and holds only while a
// result waits at the output. The exp table is constant logic, so items are taken from
// the first cycle after reset. Reset clears all stage valid bits; payload is not reset.
`default_nettype none

module selu_activation_unit #(
  parameter int unsigned ExpSegments = selu_pkg::ExpSegments
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  selu_in_if.sink    in_i,
  selu_out_if.source out_o
);

  localparam int unsigned Step  = selu_pkg::InRange / ExpSegments;
  localparam int unsigned Segs  = selu_pkg::InRange / Step + 1;
  localparam int unsigned IdxW  = $clog2(Segs);
  localparam int unsigned FracW = $clog2(Step);
  localparam int unsigned UW    = selu_pkg::UW;
  localparam int unsigned XW    = selu_pkg::XW;

  logic en;
  logic out_valid;

  assign en         = !out_valid || out_o.ready;
  assign in_i.ready = en;

  // entry: magnitude of non-positive input
  logic signed [UW-1:0] xs;
  logic [UW-1:0]        u;
  selu_pkg::side_t      side_d;

  always_comb begin
    xs          = UW'(in_i.x_value);
    side_d.op   = selu_pkg::op_e'(in_i.op);
    side_d.pos  = !in_i.x_value[XW-1] && (in_i.x_value != '0);
    side_d.x    = in_i.x_value;
    side_d.grad = in_i.grad_in;
    u           = side_d.pos ? '0 : UW'(-xs);
  end

  logic                seg_valid;
  logic [UW-1:0]       seg_quot;
  logic [FracW-1:0]    seg_frac;
  selu_pkg::side_t     seg_side;

  selu_cdiv #(
    .Divisor (Step),
    .NumW    (UW),
    .SideW   ($bits(selu_pkg::side_t))
  ) u_seg_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_i.valid),
    .num_i   (u),
    .side_i  (side_d),
    .valid_o (seg_valid),
    .quot_o  (seg_quot),
    .rem_o   (seg_frac),
    .side_o  (seg_side)
  );

  logic                          exp_valid;
  logic [selu_pkg::RomW-1:0]     exp_val;
  selu_pkg::side_t               exp_side;

  selu_exp_interp #(
    .ExpSegments (ExpSegments)
  ) u_exp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (seg_valid),
    .idx_i   (IdxW'(seg_quot)),
    .frac_i  (seg_frac),
    .side_i  (seg_side),
    .valid_o (exp_valid),
    .exp_o   (exp_val),
    .side_o  (exp_side)
  );

  logic signed [selu_pkg::RW-1:0] result;
  logic                           sat;

  selu_scale u_scale (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (exp_valid),
    .exp_i    (exp_val),
    .side_i   (exp_side),
    .valid_o  (out_valid),
    .result_o (result),
    .sat_o    (sat)
  );

  assign out_o.valid        = out_valid;
  assign out_o.result_value = result;
  assign out_o.saturated    = sat;

  a_seg_in_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seg_valid |-> (seg_quot <= UW'(Segs - 1)))
    else $error("segment index beyond exp table");

  a_exp_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exp_valid |-> (exp_val <= selu_pkg::OneQ30))
    else $error("interpolated exp above one");

  a_exp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!en && exp_valid) |=> (exp_valid && $stable(exp_val)))
    else $error("exp stage moved during stall");

  a_no_clip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> !sat)
    else $error("result clipped");

endmodule

`default_nettype wire
